FILE: rtl/rcms_pkg.sv
package rcms_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_CAL_MINIMUM     = 3'd0;
    localparam logic [2:0] REG_CAL_NEUTRAL     = 3'd1;
    localparam logic [2:0] REG_CAL_MAXIMUM     = 3'd2;
    localparam logic [2:0] REG_BRAKE_ENABLE    = 3'd3;
    localparam logic [2:0] REG_CURVE_ENABLE    = 3'd4;
    localparam logic [2:0] REG_NEUTRAL_ZONE    = 3'd5;
    localparam logic [2:0] REG_EXTREMUM_ZONE   = 3'd6;
    localparam logic [2:0] REG_BRAKE_ZONE      = 3'd7;

    localparam logic [15:0] RST_CAL_MINIMUM   = 16'd250;
    localparam logic [15:0] RST_CAL_NEUTRAL   = 16'd375;
    localparam logic [15:0] RST_CAL_MAXIMUM   = 16'd500;
    localparam logic [7:0]  RST_NEUTRAL_ZONE  = 8'd8;
    localparam logic [7:0]  RST_EXTREMUM_ZONE = 8'd8;
    localparam logic [7:0]  RST_BRAKE_ZONE    = 8'd4;

    // Per-item quotient: 25-bit dividend (17-bit distance << 8), one bit per stage
    localparam int DIV_STEPS = 25;
    localparam logic [7:0] SPEED_CEILING = 8'd255;
    localparam int CURVE_ENTRIES = 256;

    // Item after classification, waiting for the quotient pipeline
    typedef struct packed {
        logic        right;
        logic        sat;        // travel of the active side is zero or negative
        logic [16:0] offset;
        logic [15:0] divisor;
    } t_item;

    // Derived constants handed from the config block to front and back
    typedef struct packed {
        logic [16:0]        neutral_x2;
        logic signed [17:0] travel_right;
        logic signed [17:0] travel_left;
        logic [15:0]        neutral_band;
        logic [15:0]        brake_band;
        logic               brake_en;
        logic               curve_en;
    } t_consts;

    localparam logic [7:0] CURVE_ROM [CURVE_ENTRIES] = '{
        8'h00,8'h06,8'h0c,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h12,8'h13,
        8'h13,8'h13,8'h13,8'h13,8'h13,8'h13,8'h14,8'h14,8'h14,8'h14,8'h15,8'h15,8'h15,8'h15,8'h16,8'h16,
        8'h16,8'h16,8'h17,8'h17,8'h17,8'h18,8'h18,8'h18,8'h19,8'h19,8'h19,8'h1a,8'h1a,8'h1b,8'h1b,8'h1b,
        8'h1c,8'h1c,8'h1d,8'h1d,8'h1e,8'h1e,8'h1e,8'h1f,8'h1f,8'h20,8'h20,8'h21,8'h21,8'h22,8'h23,8'h23,
        8'h24,8'h24,8'h25,8'h25,8'h26,8'h27,8'h27,8'h28,8'h28,8'h29,8'h2a,8'h2a,8'h2b,8'h2c,8'h2c,8'h2d,
        8'h2e,8'h2e,8'h2f,8'h30,8'h30,8'h31,8'h32,8'h33,8'h33,8'h34,8'h35,8'h36,8'h37,8'h37,8'h38,8'h39,
        8'h3a,8'h3b,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,8'h40,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
        8'h48,8'h49,8'h4a,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,
        8'h57,8'h58,8'h59,8'h5a,8'h5c,8'h5d,8'h5e,8'h5f,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h68,
        8'h69,8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h77,8'h78,8'h79,8'h7a,
        8'h7b,8'h7d,8'h7e,8'h7f,8'h80,8'h82,8'h83,8'h84,8'h85,8'h87,8'h88,8'h89,8'h8a,8'h8c,8'h8d,8'h8e,
        8'h90,8'h91,8'h92,8'h93,8'h95,8'h96,8'h97,8'h99,8'h9a,8'h9b,8'h9d,8'h9e,8'h9f,8'ha1,8'ha2,8'ha3,
        8'ha5,8'ha6,8'ha7,8'ha9,8'haa,8'hac,8'had,8'hae,8'hb0,8'hb1,8'hb2,8'hb4,8'hb5,8'hb7,8'hb8,8'hb9,
        8'hbb,8'hbc,8'hbe,8'hbf,8'hc0,8'hc2,8'hc3,8'hc5,8'hc6,8'hc7,8'hc9,8'hca,8'hcc,8'hcd,8'hcf,8'hd0,
        8'hd1,8'hd3,8'hd4,8'hd6,8'hd7,8'hd9,8'hda,8'hdc,8'hdd,8'hde,8'he0,8'he1,8'he3,8'he4,8'he6,8'he7,
        8'he9,8'hea,8'hec,8'hed,8'hee,8'hf0,8'hf1,8'hf3,8'hf4,8'hf6,8'hf7,8'hf9,8'hfa,8'hfc,8'hfd,8'hff
    };

endpackage

FILE: rtl/rc_pulse_to_motor_speed.sv
// Path: front register, queue, the 25 quotient stages, then the output register.
// Throughput: one transaction per cycle outside a rebuild; the 25-stage quotient pipeline
//   takes a new dividend each cycle the output moves; the queue absorbs input until full.
// Reset (i_rst_n low, synchronous) loads the register defaults and empties the pipeline.
// After reset and after each config write, s_axis_tready stays low while the serial
//   divider rebuilds the zone constants (the saturated paths skip divisions).
module rc_pulse_to_motor_speed
    import rcms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pulse input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] filtered_pulse_x2
    // speed output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] direction_right, [1] brake_request,
                                        // [9:2] motor_speed, [15:10] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_consts consts;
    logic    busy;
    logic    f_valid, f_ready;
    t_item   f_item;
    logic    q_valid, q_ready;
    t_item   q_item;

    // Writes are taken whenever reset is not asserted; each one restarts the constant rebuild.
    assign o_cfg_ready = i_rst_n;

    // Registers plus the sequencer that derives travel and zone constants
    rcms_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_consts   (consts),
        .o_busy     (busy)
    );

    // Front: picks side, distance from neutral and divisor for each pulse
    rcms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_busy       (busy),
        .i_consts     (consts),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pulse_x2   (s_axis_tdata),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    // Queue decouples classification from the quotient pipeline
    rcms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    // Back: one quotient bit per stage, then zone, clamp, curve into the output register
    rcms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_consts     (consts),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule

FILE: rtl/rcms_cfg.sv
module rcms_cfg
    import rcms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_consts     o_consts,
    output logic        o_busy
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_ZONE, S_DIV1, S_MUL1, S_DIV2, S_BRK, S_DIV3
    } t_state;

    localparam logic [4:0] DIV_LAST = 5'd23;

    t_state r_state;
    logic [15:0] r_cal_min, r_cal_neu, r_cal_max;
    logic        r_brake_en, r_curve_en;
    logic [7:0]  r_nz, r_ez, r_bz;
    logic signed [17:0] r_travel_right, r_travel_left, r_sum;
    logic signed [16:0] r_span;
    logic [15:0] r_neutral_band, r_brake_band;

    // shared serial divider: 24-bit dividend, 16-bit divisor
    logic [23:0] r_dvd;
    logic [15:0] r_rem, r_dvs;
    logic [4:0]  r_cnt;

    logic [16:0] trial;
    logic        ge;
    logic [15:0] n_rem;
    logic [23:0] n_dvd;
    logic signed [17:0] tr_calc, tl_calc;
    logic [32:0] prod_span;
    logic [23:0] prod_brake;
    logic [23:0] zone_dvd;

    function automatic logic [15:0] sat16(input logic [23:0] v);
        return (|v[23:16]) ? 16'hFFFF : v[15:0];
    endfunction

    always_comb begin
        trial = {r_rem, r_dvd[23]};
        ge    = trial >= {1'b0, r_dvs};
        n_rem = ge ? 16'(trial - {1'b0, r_dvs}) : trial[15:0];
        n_dvd = {r_dvd[22:0], ge};
        tr_calc = $signed({2'b00, r_cal_max}) - $signed({2'b00, r_cal_neu})
                - $signed({10'd0, r_nz}) - $signed({10'd0, r_ez});
        tl_calc = $signed({2'b00, r_cal_neu}) - $signed({2'b00, r_cal_min})
                - $signed({10'd0, r_nz}) - $signed({10'd0, r_ez});
        prod_span  = r_dvd[16:0] * r_span[15:0];
        prod_brake = r_neutral_band * r_bz;
        // nz * 0x1fe as (nz << 9) - (nz << 1)
        zone_dvd = {7'd0, r_nz, 9'd0} - {15'd0, r_nz, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_PREP;
            r_cal_min  <= RST_CAL_MINIMUM;
            r_cal_neu  <= RST_CAL_NEUTRAL;
            r_cal_max  <= RST_CAL_MAXIMUM;
            r_brake_en <= 1'b0;
            r_curve_en <= 1'b0;
            r_nz       <= RST_NEUTRAL_ZONE;
            r_ez       <= RST_EXTREMUM_ZONE;
            r_bz       <= RST_BRAKE_ZONE;
        end else if (i_wr_en) begin
            // a write restarts the rebuild from scratch
            r_state <= S_PREP;
            unique case (i_wr_index)
                REG_CAL_MINIMUM:   r_cal_min  <= i_wr_data;
                REG_CAL_NEUTRAL:   r_cal_neu  <= i_wr_data;
                REG_CAL_MAXIMUM:   r_cal_max  <= i_wr_data;
                REG_BRAKE_ENABLE:  r_brake_en <= i_wr_data[0];
                REG_CURVE_ENABLE:  r_curve_en <= i_wr_data[0];
                REG_NEUTRAL_ZONE:  r_nz       <= i_wr_data[7:0];
                REG_EXTREMUM_ZONE: r_ez       <= i_wr_data[7:0];
                REG_BRAKE_ZONE:    r_bz       <= i_wr_data[7:0];
            endcase
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                end
                S_PREP: begin
                    r_travel_right <= tr_calc;
                    r_travel_left  <= tl_calc;
                    r_sum          <= tr_calc + tl_calc;
                    r_span <= $signed({1'b0, r_cal_max}) - $signed({1'b0, r_cal_min});
                    r_state <= S_ZONE;
                end
                S_ZONE: begin
                    if (r_span[16] || r_span == '0 || r_sum[17] || r_sum == '0) begin
                        r_neutral_band <= 16'hFFFF;
                        r_state        <= S_BRK;
                    end else begin
                        r_dvd   <= zone_dvd;
                        r_rem   <= '0;
                        r_dvs   <= r_span[15:0];
                        r_cnt   <= '0;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1, S_DIV2, S_DIV3: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        if (r_state == S_DIV1) begin
                            r_state <= S_MUL1;
                        end else if (r_state == S_DIV2) begin
                            r_neutral_band <= sat16(n_dvd);
                            r_state        <= S_BRK;
                        end else begin
                            r_brake_band <= sat16(n_dvd);
                            r_state      <= S_IDLE;
                        end
                    end
                end
                S_MUL1: begin
                    // quotient * span never exceeds nz * 0x1fe
                    r_dvd   <= prod_span[23:0];
                    r_rem   <= '0;
                    r_dvs   <= r_sum[15:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV2;
                end
                S_BRK: begin
                    if (r_nz == '0) begin
                        r_brake_band <= '0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_dvd   <= prod_brake;
                        r_rem   <= '0;
                        r_dvs   <= {8'd0, r_nz};
                        r_cnt   <= '0;
                        r_state <= S_DIV3;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_consts.neutral_x2   = {r_cal_neu, 1'b0};
        o_consts.travel_right = r_travel_right;
        o_consts.travel_left  = r_travel_left;
        o_consts.neutral_band = r_neutral_band;
        o_consts.brake_band   = r_brake_band;
        o_consts.brake_en     = r_brake_en;
        o_consts.curve_en     = r_curve_en;
    end

endmodule

FILE: rtl/rcms_front.sv
module rcms_front
    import rcms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_busy,
    input  t_consts     i_consts,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_pulse_x2,
    output logic        o_item_valid,
    input  logic        i_item_ready,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;
    logic signed [17:0] travel;

    assign o_ready = i_rst_n && !i_busy && (!r_valid || i_item_ready);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_item.right  = {1'b0, i_pulse_x2} > i_consts.neutral_x2;
        n_item.offset = n_item.right ? ({1'b0, i_pulse_x2} - i_consts.neutral_x2)
                                     : (i_consts.neutral_x2 - {1'b0, i_pulse_x2});
        travel = n_item.right ? i_consts.travel_right : i_consts.travel_left;
        n_item.sat     = travel[17] || (travel == '0);
        n_item.divisor = travel[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_item_ready);
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: rtl/rcms_queue.sv
module rcms_queue
    import rcms_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;
    assign o_pop_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: rtl/rcms_back.sv
module rcms_back
    import rcms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_consts     i_consts,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_data
);

    typedef struct packed {
        logic        right;
        logic        sat;
        logic [15:0] rem;
        logic [24:0] quo;   // dividend bits shift out, quotient bits shift in
        logic [15:0] dvs;
    } t_stage;

    t_stage r_stg     [DIV_STEPS];
    logic   r_stg_vld [DIV_STEPS];
    logic   r_out_valid;
    logic [15:0] r_out_data;

    logic   en;
    t_stage head;
    t_stage last;
    logic [23:0] q_half;
    logic [23:0] diff;
    logic        brake;
    logic [7:0]  speed, result;

    function automatic t_stage div_step(input t_stage s);
        logic [16:0] trial;
        logic        ge;
        t_stage      r;
        r     = s;
        trial = {s.rem, s.quo[24]};
        ge    = trial >= {1'b0, s.dvs};
        r.rem = ge ? 16'(trial - {1'b0, s.dvs}) : trial[15:0];
        r.quo = {s.quo[23:0], ge};
        return r;
    endfunction

    assign en = !r_out_valid || i_ready;
    assign o_item_ready = en;

    always_comb begin
        head.right = i_item.right;
        head.sat   = i_item.sat;
        head.rem   = '0;
        head.quo   = {i_item.offset, 8'h00};
        head.dvs   = i_item.divisor;

        last   = r_stg[DIV_STEPS-1];
        q_half = last.sat ? '1 : last.quo[24:1];
        brake  = i_consts.brake_en && (q_half <= {8'h00, i_consts.brake_band});
        diff   = q_half - {8'h00, i_consts.neutral_band};
        if (q_half <= {8'h00, i_consts.neutral_band}) begin
            speed = '0;
        end else if (diff > {16'h0000, SPEED_CEILING}) begin
            speed = SPEED_CEILING;
        end else begin
            speed = diff[7:0];
        end
        result = i_consts.curve_en ? CURVE_ROM[speed] : speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_stg_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_stg_vld[0] <= i_item_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_stg_vld[k] <= r_stg_vld[k-1];
            end
            r_out_valid <= r_stg_vld[DIV_STEPS-1];
        end
        if (en) begin
            r_stg[0] <= div_step(head);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_stg[k] <= div_step(r_stg[k-1]);
            end
            r_out_data <= {6'd0, result, brake, last.right};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/rcms_checker.sv
module rcms_checker
    import rcms_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    logic r_brake_en;
    logic cfg_wr;

    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // shadow of the brake enable register as seen on the config channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_en <= 1'b0;
        end else if (cfg_wr && i_cfg_index == REG_BRAKE_ENABLE) begin
            r_brake_en <= i_cfg_data[0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == '0)
        else $error("padding bits of output data not zero");

    a_brake_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_brake_en |-> !m_axis_tdata[1])
        else $error("brake request with braking disabled");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !s_axis_tready)
        else $error("input accepted while constants are rebuilt");

endmodule

bind rc_pulse_to_motor_speed rcms_checker u_rcms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);
